// ----- design/modular_exponentiation_macros.svh -----
// ----------------------------------------------------------------------------
// Modular exponentiation assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// Same-cycle implication.
`define MEXP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("modular_exponentiation: assertion failed");

// Next-cycle implication.
`define MEXP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("modular_exponentiation: assertion failed");

`endif

// ----- design/mexp_pkg.sv -----
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Widths, register map, datapath operation codes and the command and status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int CNT_W      = $clog2(DATA_WIDTH);
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [DATA_WIDTH-1:0] MODULUS_RESET = DATA_WIDTH'(13);

  // Register index taken from paddr[2].
  localparam logic REG_MODULUS = 1'b0;

  typedef enum logic [1:0] {
    OP_PRE = 2'd0,
    OP_MUL = 2'd1,
    OP_SQR = 2'd2
  } op_t;

  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic wb;
    logic shift_e;
    logic out_load;
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic e_zero;
    logic e_lsb;
  } dp_stat_t;

endpackage

// ----- design/mexp_datapath.sv -----
// ----------------------------------------------------------------------------
// Modular exponentiation datapath
// Holds the modulus register, the operands, the exponent shifter and one
// bit-serial interleaved modular multiplier shared by every operation.
// ----------------------------------------------------------------------------
module mexp_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mexp_pkg::dp_cmd_t                   cmd,
  output mexp_pkg::dp_stat_t                  stat,
  input  logic [mexp_pkg::DATA_WIDTH-1:0]     base,
  input  logic [mexp_pkg::DATA_WIDTH-1:0]     exponent,
  output logic [mexp_pkg::DATA_WIDTH-1:0]     power_mod,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [mexp_pkg::PADDR_W-1:0]        cfg_paddr,
  input  logic [mexp_pkg::PDATA_W-1:0]        cfg_pwdata,
  output logic [mexp_pkg::PDATA_W-1:0]        cfg_prdata
);
  import mexp_pkg::*;

  localparam int TW = DATA_WIDTH + 2;

  logic [DATA_WIDTH-1:0] mod_r, mod_nxt;
  logic [DATA_WIDTH-1:0] run_r, run_nxt;
  logic [DATA_WIDTH-1:0] acc_r, acc_nxt;
  logic [DATA_WIDTH-1:0] e_r, e_nxt;
  logic [DATA_WIDTH-1:0] a_r, a_nxt;
  logic [DATA_WIDTH-1:0] b_r, b_nxt;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] out_r, out_nxt;
  logic [TW-1:0]         t_sum;
  logic [TW-1:0]         m_one;
  logic [TW-1:0]         m_two;
  logic [TW-1:0]         t_red;
  logic                  mod_zero;
  logic                  cfg_wr;

  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_MODULUS);
  assign mod_zero = (mod_r == '0);

  always_comb begin
    mod_nxt = mod_r;
    if (cfg_wr) begin
      mod_nxt = cfg_pwdata[DATA_WIDTH-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_MODULUS) begin
      cfg_prdata = PDATA_W'(mod_r);
    end
  end

  // One step of the MSB-first interleaved multiplier; the sum stays below 3m.
  always_comb begin
    m_one = TW'(mod_r);
    m_two = {1'b0, mod_r, 1'b0};
    t_sum = {1'b0, rem_r, 1'b0} + (b_r[DATA_WIDTH-1] ? TW'(a_r) : TW'(0));
    if (mod_zero) begin
      t_red = t_sum;
    end else if (t_sum >= m_two) begin
      t_red = t_sum - m_two;
    end else if (t_sum >= m_one) begin
      t_red = t_sum - m_one;
    end else begin
      t_red = t_sum;
    end
  end

  always_comb begin
    run_nxt = run_r;
    acc_nxt = acc_r;
    e_nxt   = e_r;
    a_nxt   = a_r;
    b_nxt   = b_r;
    rem_nxt = rem_r;
    out_nxt = out_r;
    if (cmd.load) begin
      run_nxt = base;
      e_nxt   = exponent;
      acc_nxt = DATA_WIDTH'(1);
    end
    if (cmd.start) begin
      rem_nxt = '0;
      unique case (cmd.op)
        OP_PRE: begin
          a_nxt = DATA_WIDTH'(1);
          b_nxt = run_r;
        end
        OP_MUL: begin
          a_nxt = run_r;
          b_nxt = acc_r;
        end
        OP_SQR: begin
          a_nxt = run_r;
          b_nxt = run_r;
        end
        default: begin
          a_nxt = a_r;
          b_nxt = b_r;
        end
      endcase
    end
    if (cmd.step) begin
      rem_nxt = t_red[DATA_WIDTH-1:0];
      b_nxt   = {b_r[DATA_WIDTH-2:0], 1'b0};
    end
    if (cmd.wb) begin
      if (cmd.op == OP_MUL) begin
        acc_nxt = rem_r;
      end else begin
        run_nxt = rem_r;
      end
    end
    if (cmd.shift_e) begin
      e_nxt = {1'b0, e_r[DATA_WIDTH-1:1]};
    end
    if (cmd.out_load) begin
      out_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= MODULUS_RESET;
    end else begin
      mod_r <= mod_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_r <= run_nxt;
    acc_r <= acc_nxt;
    e_r   <= e_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    rem_r <= rem_nxt;
    out_r <= out_nxt;
  end

  assign stat.e_zero = (e_r == '0);
  assign stat.e_lsb  = e_r[0];
  assign power_mod   = out_r;

endmodule

// ----- design/mexp_ctrl.sv -----
// ----------------------------------------------------------------------------
// Modular exponentiation controller
// Sequences base reduction, multiply and square operations on the shared
// multiplier and runs both handshakes.
// ----------------------------------------------------------------------------
module mexp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output mexp_pkg::dp_cmd_t  cmd,
  input  mexp_pkg::dp_stat_t stat
);
  import mexp_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_START = 6'b000010,
    S_STEP  = 6'b000100,
    S_WB    = 6'b001000,
    S_CHECK = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.op    = op_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          op_nxt    = OP_PRE;
          state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.start = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DATA_WIDTH - 1)) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        cmd.wb = 1'b1;
        unique case (op_r)
          OP_MUL: begin
            op_nxt    = OP_SQR;
            state_nxt = S_START;
          end
          OP_SQR: begin
            cmd.shift_e = 1'b1;
            state_nxt   = S_CHECK;
          end
          default: begin
            state_nxt = S_CHECK;
          end
        endcase
      end
      S_CHECK: begin
        if (stat.e_zero) begin
          state_nxt = S_FIN;
        end else begin
          op_nxt    = stat.e_lsb ? OP_MUL : OP_SQR;
          state_nxt = S_START;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_PRE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- design/modular_exponentiation.sv -----
// ----------------------------------------------------------------------------
// Modular exponentiation
// Right-to-left square-and-multiply: base to the power exponent, reduced by
// the modulus register.
// ----------------------------------------------------------------------------
// One word is worked at a time on a single bit-serial modular multiplier; each
// operation runs through start, 16 steps and write-back. The base is first
// reduced by one such operation, then every exponent bit up to the highest
// set one costs one square plus one multiply when the bit is set, and a check
// state. An exponent of zero returns 1. A new word is accepted while the
// previous result still waits on the output. A modulus of zero gives products
// wrapped to 16 bits.
module modular_exponentiation (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mexp_pkg::DATA_WIDTH-1:0]   in_base,
  input  logic [mexp_pkg::DATA_WIDTH-1:0]   in_exponent,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mexp_pkg::DATA_WIDTH-1:0]   out_power_mod,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [mexp_pkg::PADDR_W-1:0]      cfg_paddr,
  input  logic [mexp_pkg::PDATA_W-1:0]      cfg_pwdata,
  output logic [mexp_pkg::PDATA_W-1:0]      cfg_prdata,
  output logic                              cfg_pready
);
  import mexp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_pready = 1'b1;

  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  mexp_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .base        (in_base),
    .exponent    (in_exponent),
    .power_mod   (out_power_mod),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata)
  );

endmodule

// ----- design/mexp_checker.sv -----
// ----------------------------------------------------------------------------
// Modular exponentiation checker
// Port-level assertions on the result handshake, busy behavior and the
// modulus register, bound to the top level.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_macros.svh"

module mexp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [mexp_pkg::DATA_WIDTH-1:0]   out_power_mod,
  input logic                              cfg_psel,
  input logic                              cfg_penable,
  input logic                              cfg_pwrite,
  input logic [mexp_pkg::PADDR_W-1:0]      cfg_paddr,
  input logic [mexp_pkg::PDATA_W-1:0]      cfg_pwdata,
  input logic [mexp_pkg::PDATA_W-1:0]      cfg_prdata,
  input logic                              cfg_pready
);
  import mexp_pkg::*;

  logic                  reg_hit;
  logic                  mod_wr;
  logic [DATA_WIDTH-1:0] wdata_lo;
  logic [DATA_WIDTH-1:0] rdata_lo;

  assign reg_hit  = (cfg_paddr[2] == REG_MODULUS);
  assign mod_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_hit;
  assign wdata_lo = cfg_pwdata[DATA_WIDTH-1:0];
  assign rdata_lo = cfg_prdata[DATA_WIDTH-1:0];

  // A waiting result keeps its value.
  `MEXP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_power_mod))

  // The block is busy right after it takes a word.
  `MEXP_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // A new result appears only as the block returns to idle.
  `MEXP_ASSERT_IMP(a_result_then_idle, $rose(out_valid), in_ready)

  // A modulus write reads back on the next cycle.
  `MEXP_ASSERT_NXT(a_modulus_readback, mod_wr, !reg_hit || (rdata_lo == $past(wdata_lo)))

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (.*);

// ----- verif/tb_modular_exponentiation.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Feeds base and exponent words through a valid/ready driver and checks every
// power_mod word against a square-and-multiply predictor that tracks the
// modulus written over the APB port. A directed set covers the field extremes
// and the zero exponent, unit modulus, zero modulus and unmapped register
// cases. Random phases then sweep several modulus settings under changing
// sender and receiver idling, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation;
  import mexp_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 11;
  localparam int PHASES       = 9;
  localparam int PHASE_WORDS  = 55;
  localparam int MAX_REPORTS  = 10;
  localparam int TAIL_CYCLES  = 50;
  localparam int HOLD_CYCLES  = 2000;
  localparam longint TIMEOUT_CYCLES = 2_000_000;

  typedef logic [DATA_WIDTH-1:0]   word_t;
  typedef logic [2*DATA_WIDTH-1:0] product_t;

  localparam word_t ALL_ONES = '1;
  localparam logic [PADDR_W-1:0] MODULUS_ADDR  = {REG_MODULUS, 2'b00};
  localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = {!REG_MODULUS, 2'b00};

  typedef struct packed {
    word_t base;
    word_t exponent;
  } operand_pair_t;

  typedef struct packed {
    word_t base;
    word_t exponent;
    word_t power_mod;
  } expected_power_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  word_t              in_base = '0;
  word_t              in_exponent = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  word_t              out_power_mod;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0] cfg_paddr = '0;
  logic [PDATA_W-1:0] cfg_pwdata = '0;
  logic [PDATA_W-1:0] cfg_prdata;
  logic               cfg_pready;

  operand_pair_t   pending_words[$];
  expected_power_t expected_results[$];
  word_t           modulus_setting = MODULUS_RESET;
  int              sender_idle_pct = 6;
  int              receiver_idle_pct = 45;
  int              hold_left = 0;
  int              error_count = 0;

  modular_exponentiation dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_base       (in_base),
    .in_exponent   (in_exponent),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_power_mod (out_power_mod),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic word_t mod_product(word_t a, word_t b, word_t modulus);
    product_t prod;
    prod = a * b;
    if (modulus == '0) begin
      return prod[DATA_WIDTH-1:0];
    end
    return word_t'(prod % modulus);
  endfunction

  // The accumulator starts at one and is never reduced on its own, so a zero
  // exponent returns one whatever the modulus.
  function automatic word_t predict_power_mod(word_t base, word_t exponent, word_t modulus);
    word_t acc;
    word_t running;
    word_t bits_left;
    acc = word_t'(1);
    running = base;
    bits_left = exponent;
    while (bits_left != '0) begin
      if (bits_left[0]) begin
        acc = mod_product(acc, running, modulus);
      end
      bits_left = bits_left >> 1;
      running = mod_product(running, running, modulus);
    end
    return acc;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endtask

  task automatic queue_operands(input word_t base, input word_t exponent);
    pending_words.push_back('{base: base, exponent: exponent});
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic apb_transfer(input logic is_write, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= is_write;
    cfg_paddr <= addr;
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) begin
      @(posedge clk);
    end
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (is_write && addr[2] == REG_MODULUS) begin
      modulus_setting = wdata[DATA_WIDTH-1:0];
    end
  endtask

  // Only called while no word is in flight. The upper data bits carry noise.
  task automatic set_modulus(input logic [PADDR_W-1:0] addr, input word_t value);
    logic [PDATA_W-1:0] readback;
    apb_transfer(1'b1, addr, {(PDATA_W-DATA_WIDTH)'($urandom()), value}, readback);
    apb_transfer(1'b0, MODULUS_ADDR, '0, readback);
    if (readback[DATA_WIDTH-1:0] !== modulus_setting) begin
      report_mismatch($sformatf("modulus readback: expected %0d, got %0d",
                                modulus_setting, readback[DATA_WIDTH-1:0]));
    end
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    operand_pair_t next_word;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back('{base: in_base, exponent: in_exponent,
            power_mod: predict_power_mod(in_base, in_exponent, modulus_setting)});
      end
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_word = pending_words.pop_front();
          in_valid <= 1'b1;
          in_base <= next_word.base;
          in_exponent <= next_word.exponent;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    expected_power_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected word: power_mod %0d", out_power_mod));
      end else begin
        want = expected_results.pop_front();
        if (out_power_mod !== want.power_mod) begin
          report_mismatch($sformatf("base %0d exponent %0d: expected %0d, got %0d",
                                    want.base, want.exponent, want.power_mod,
                                    out_power_mod));
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("modular_exponentiation regression: fail");
    $finish;
  end

  initial begin
    word_t phase_moduli[PHASES];
    word_t base;
    word_t exponent;
    int    phase;
    int    n;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words at the reset modulus.
    queue_operands(16'd0, 16'd0);
    queue_operands(16'd0, 16'd1);
    queue_operands(16'd1, ALL_ONES);
    queue_operands(ALL_ONES, ALL_ONES);
    queue_operands(ALL_ONES, 16'd0);
    queue_operands(16'd12, 16'd2);
    queue_operands(16'd5, 16'h8000);
    queue_operands(16'd7, 16'h5555);
    queue_operands(16'd3, 16'hAAAA);
    queue_operands(16'd13, 16'd5);
    wait_drained();

    // A write outside the register map must leave the modulus alone.
    set_modulus(UNMAPPED_ADDR, 16'd7);
    queue_operands(16'd2, 16'd10);
    wait_drained();

    set_modulus(MODULUS_ADDR, 16'd1);
    queue_operands(16'd5, 16'd0);
    queue_operands(16'd5, 16'd3);
    queue_operands(16'd0, 16'd0);
    wait_drained();

    // With a zero modulus the products simply wrap.
    set_modulus(MODULUS_ADDR, 16'd0);
    queue_operands(ALL_ONES, 16'd2);
    queue_operands(16'd3, ALL_ONES);
    queue_operands(16'd256, 16'd2);
    queue_operands(16'd0, 16'd0);
    wait_drained();

    set_modulus(MODULUS_ADDR, ALL_ONES);
    queue_operands(16'hFFFE, ALL_ONES);
    queue_operands(16'd2, 16'd16);
    wait_drained();

    phase_moduli = '{ALL_ONES, 16'd65521, word_t'($urandom_range(65534, 3)),
                     16'd1, 16'd2, 16'd32768,
                     word_t'($urandom_range(300, 3)), 16'd0,
                     word_t'($urandom_range(65534, 3))};

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase / 3)
        0: begin
          sender_idle_pct = 6;
          receiver_idle_pct = 45;
        end
        1: begin
          sender_idle_pct = 45;
          receiver_idle_pct = 6;
        end
        default: begin
          sender_idle_pct = 0;
          receiver_idle_pct = 0;
        end
      endcase
      set_modulus(MODULUS_ADDR, phase_moduli[phase]);
      // The receiver stops for a long stretch so that the block backs up.
      if (phase == 4) begin
        hold_left = HOLD_CYCLES;
      end
      for (n = 0; n < PHASE_WORDS; n++) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: exponent = word_t'($urandom());
          6, 7: exponent = word_t'($urandom_range(15));
          8: exponent = word_t'(1) << $urandom_range(DATA_WIDTH - 1);
          default: exponent = ALL_ONES >> $urandom_range(DATA_WIDTH - 1);
        endcase
        case ($urandom_range(9))
          0: base = '0;
          1: base = word_t'(1);
          2: base = modulus_setting - word_t'(1);
          3: base = modulus_setting;
          4: base = ALL_ONES;
          default: base = word_t'($urandom());
        endcase
        queue_operands(base, exponent);
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("modular_exponentiation regression: pass");
    end else begin
      $display("modular_exponentiation regression: fail");
    end
    $finish;
  end

endmodule
